>>> src/signed_integer_divider_unit_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the signed integer divider
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// -----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_DIVIDER_UNIT_MACROS_SVH
`define SIGNED_INTEGER_DIVIDER_UNIT_MACROS_SVH

// same-cycle implication
`define SIDU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SIDU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sidu_pkg.sv
// -----------------------------------------------------------------------------
// sidu_pkg
// Widths, state encoding and controller/datapath interface types.
// -----------------------------------------------------------------------------
package sidu_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [WIDTH-1:0] INT_MAX = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic [WIDTH-1:0] INT_MIN = {1'b1, {(WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_FIX
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

>>> src/sidu_ctrl.sv
// -----------------------------------------------------------------------------
// sidu_ctrl
// Sequencer: load, one quotient bit per cycle, sign fix into output register.
// -----------------------------------------------------------------------------
module sidu_ctrl
    import sidu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ITER;
                end
            end
            S_ITER: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> src/sidu_datapath.sv
// -----------------------------------------------------------------------------
// sidu_datapath
// Magnitude restoring division, bit counter, sign correction, result register.
// -----------------------------------------------------------------------------
module sidu_datapath
    import sidu_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [WIDTH-1:0] i_dividend,
    input  logic signed [WIDTH-1:0] i_divisor,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    output logic signed [WIDTH-1:0] o_quotient
);

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] n_num;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] n_den;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_b_zero;
    logic             r_a_zero;
    logic             r_a_pos;
    logic             r_neg;
    logic [WIDTH-1:0] r_quotient;
    logic [WIDTH-1:0] n_quotient;

    logic [WIDTH-1:0] ua;
    logic [WIDTH-1:0] ub;
    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             ge;
    logic [WIDTH-1:0] neg_q;

    assign ua    = i_dividend;
    assign ub    = i_divisor;
    assign mag_a = ua[WIDTH-1] ? (~ua + WIDTH'(1)) : ua;
    assign mag_b = ub[WIDTH-1] ? (~ub + WIDTH'(1)) : ub;

    assign trial = {r_rem, r_num[WIDTH-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign neg_q = ~r_num + WIDTH'(1);

    always_comb begin
        n_num = r_num;
        n_den = r_den;
        n_rem = r_rem;
        n_cnt = r_cnt;
        priority if (i_cmd.load) begin
            n_num = mag_a;
            n_den = mag_b;
            n_rem = '0;
            n_cnt = CNT_W'(WIDTH - 1);
        end else if (i_cmd.step) begin
            n_num = {r_num[WIDTH-2:0], ge};
            n_rem = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            n_cnt = r_cnt - CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_comb begin
        priority if (r_b_zero) begin
            n_quotient = r_a_pos ? INT_MAX : INT_MIN;
        end else if (r_a_zero) begin
            n_quotient = '0;
        end else if (r_neg) begin
            n_quotient = neg_q;
        end else if (r_num[WIDTH-1]) begin
            n_quotient = INT_MAX;
        end else begin
            n_quotient = r_num;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_cmd.load) begin
            r_b_zero <= (ub == '0);
            r_a_zero <= (ua == '0);
            r_a_pos  <= !ua[WIDTH-1] && (ua != '0);
            r_neg    <= ua[WIDTH-1] ^ ub[WIDTH-1];
        end
        if (i_cmd.finish) begin
            r_quotient <= n_quotient;
        end
    end

    assign o_status.last = (r_cnt == '0);
    assign o_quotient    = r_quotient;

endmodule

>>> src/signed_integer_divider_unit.sv
// -----------------------------------------------------------------------------
// signed_integer_divider_unit
// 32-bit signed divider, quotient truncated toward zero.
// -----------------------------------------------------------------------------
// One request at a time: a request is taken when idle, the magnitudes are
// divided by restoring shift-and-subtract at one quotient bit per cycle
// through a single 33-bit subtractor, then the sign step applies the sign
// and writes the output register, and the unit is idle again. A finished
// result waits in the output register while the next request is accepted;
// the sign step holds only if that register is still full. Overflow (most
// negative by minus one) saturates to the largest positive value; a zero
// divisor gives the largest positive value for a positive dividend, else
// the most negative.
// -----------------------------------------------------------------------------
`include "signed_integer_divider_unit_macros.svh"

module signed_integer_divider_unit
    import sidu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [WIDTH-1:0] i_dividend,
    input  logic signed [WIDTH-1:0] i_divisor,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [WIDTH-1:0] o_quotient
);

    t_cmd    cmd;
    t_status status;

    sidu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sidu_datapath u_datapath (
        .i_clk      (i_clk),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_quotient (o_quotient)
    );

    `SIDU_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd), "overlapping commands")
    `SIDU_ASSERT_NOW(a_no_overwrite, cmd.finish, !o_out_valid || i_out_ready, "result overwritten")
    `SIDU_ASSERT_NEXT(a_busy_after_load, i_in_valid && o_in_ready, !o_in_ready, "ready while busy")

endmodule

>>> dv/tb_signed_integer_divider_unit.sv
// -----------------------------------------------------------------------------
// tb_signed_integer_divider_unit
// Self-checking bench for the 32-bit signed divider. Directed corner requests
// (zero divisor, overflow, sign combinations) are followed by random operand
// pairs. Quotients are predicted per request and checked in order, with
// random gaps on the request side, random stalls and one long hold-off on
// the result side.
// -----------------------------------------------------------------------------
module tb_signed_integer_divider_unit
    import sidu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM  = 1100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 250;

    typedef struct {
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct {
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        logic [WIDTH-1:0] quotient;
    } t_quot_exp;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic signed [WIDTH-1:0] i_dividend  = '0;
    logic signed [WIDTH-1:0] i_divisor   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [WIDTH-1:0] o_quotient;

    t_div_req  div_requests[$];
    t_quot_exp quot_expect[$];

    logic req_taken  = 1'b0;
    logic hold_done  = 1'b0;
    int   n_total    = 0;
    int   n_sent     = 0;
    int   n_quot     = 0;
    int   n_err      = 0;
    int   n_cycles   = 0;
    int   send_gap   = 0;
    int   recv_stall = 0;
    int   hold_cnt   = 0;

    signed_integer_divider_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_quotient  (o_quotient)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [WIDTH-1:0] predict_quotient(logic [WIDTH-1:0] num,
                                                          logic [WIDTH-1:0] den);
        logic             num_neg;
        logic             den_neg;
        logic [WIDTH-1:0] mag_num;
        logic [WIDTH-1:0] mag_den;
        logic [WIDTH-1:0] quo;
        num_neg = num[WIDTH-1];
        den_neg = den[WIDTH-1];
        if (den == '0) begin
            return (!num_neg && num != '0) ? INT_MAX : INT_MIN;
        end
        if (num == '0) begin
            return '0;
        end
        mag_num = num_neg ? -num : num;
        mag_den = den_neg ? -den : den;
        quo = mag_num / mag_den;
        if (num_neg != den_neg) begin
            return -quo;
        end
        return quo[WIDTH-1] ? INT_MAX : quo;
    endfunction

    function automatic logic [WIDTH-1:0] pick_operand(bit allow_zero);
        logic [WIDTH-1:0] val;
        case ($urandom_range(0, 11))
            0, 1, 2, 3: val = $urandom;
            4, 5:       val = $urandom_range(0, 200) - 100;
            6: begin
                case ($urandom_range(0, 4))
                    0:       val = '0;
                    1:       val = 1;
                    2:       val = '1;
                    3:       val = INT_MIN;
                    default: val = INT_MAX;
                endcase
            end
            7, 8, 9: begin
                val = $urandom >> $urandom_range(0, WIDTH - 1);
                if ($urandom_range(0, 1) == 1) begin
                    val = -val;
                end
            end
            10:      val = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(WIDTH-1){1'b0}}}
                           | ($urandom & 32'h0000_00ff);
            default: val = allow_zero ? '0 : 1;
        endcase
        return val;
    endfunction

    task automatic add_request(logic [WIDTH-1:0] num, logic [WIDTH-1:0] den);
        t_div_req req;
        req.dividend = num;
        req.divisor  = den;
        div_requests.push_back(req);
    endtask

    // request side
    always @(negedge i_clk) begin
        t_div_req req;
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (div_requests.size() > 0) begin
                req = div_requests.pop_front();
                i_in_valid <= 1'b1;
                i_dividend <= req.dividend;
                i_divisor  <= req.divisor;
                n_sent     <= n_sent + 1;
                if (n_sent < n_total - 150 && (n_sent / 128) % 3 != 2
                        && $urandom_range(0, 3) == 0) begin
                    send_gap <= $urandom_range(1, 10);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && n_quot >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_cnt    <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall  <= recv_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (n_quot < n_total - 150 && (n_quot / 100) % 3 != 1
                    && $urandom_range(0, 5) == 0) begin
                recv_stall <= $urandom_range(1, 10);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_quot_exp exp_q;
        req_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_quot <= n_quot + 1;
                if (quot_expect.size() == 0) begin
                    $display("%0t: unexpected quotient %0d", $time, o_quotient);
                    n_err <= n_err + 1;
                end else begin
                    exp_q = quot_expect.pop_front();
                    if (o_quotient !== exp_q.quotient) begin
                        $display("%0t: quotient of %0d / %0d: expected %0d, actual %0d",
                                 $time, $signed(exp_q.dividend), $signed(exp_q.divisor),
                                 $signed(exp_q.quotient), o_quotient);
                        n_err <= n_err + 1;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                exp_q.dividend = i_dividend;
                exp_q.divisor  = i_divisor;
                exp_q.quotient = predict_quotient(i_dividend, i_divisor);
                quot_expect.push_back(exp_q);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("tb_signed_integer_divider_unit: errors");
            $finish;
        end
    end

    initial begin
        add_request(0, 5);
        add_request(0, 0);
        add_request(5, 0);
        add_request(-5, 0);
        add_request(INT_MIN, 0);
        add_request(INT_MAX, 0);
        add_request(INT_MIN, '1);
        add_request(INT_MIN, 1);
        add_request(INT_MAX, 1);
        add_request(INT_MAX, '1);
        add_request(INT_MIN, INT_MIN);
        add_request(INT_MAX, INT_MAX);
        add_request(INT_MIN, INT_MAX);
        add_request(INT_MAX, INT_MIN);
        add_request(7, 2);
        add_request(-7, 2);
        add_request(7, -2);
        add_request(-7, -2);
        add_request(1, INT_MAX);
        add_request('1, 1);
        add_request(1, '1);
        add_request(3, 7);
        add_request('1, '1);
        add_request(32'h5555_5555, 32'haaaa_aaaa);
        add_request(32'haaaa_aaaa, 32'h5555_5555);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            add_request(pick_operand(1'b1),
                        ($urandom_range(0, 15) == 0) ? '0 : pick_operand(1'b0));
        end
        n_total = div_requests.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (div_requests.size() > 0 || i_in_valid || quot_expect.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_err == 0 && quot_expect.size() == 0) begin
            $display("tb_signed_integer_divider_unit: clean");
        end else begin
            $display("tb_signed_integer_divider_unit: errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/sidu_pkg.sv
src/sidu_ctrl.sv
src/sidu_datapath.sv
src/signed_integer_divider_unit.sv
dv/tb_signed_integer_divider_unit.sv
